FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the weighted_bin_counter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted
`define WBC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define WBC_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/wbc_pkg.sv
// ----------------------------------------------------------------------------
// wbc_pkg
// Types and constants of the weighted bin counter.
// ----------------------------------------------------------------------------
package wbc_pkg;

    // Bin memory geometry
    localparam int NUM_BINS = 1024;
    localparam int BIN_AW   = $clog2(NUM_BINS);

    // Field widths
    localparam int ACT_W      = 2;
    localparam int VAL_W      = 16;
    localparam int WGT_W      = 32;
    localparam int IDX_W      = 10;
    localparam int BIN_W      = 48;
    localparam int LEN_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Largest tracked value (fits the length field)
    localparam logic [LEN_W-1:0] TRACK_MAX = '1;

    // Q32.16 constants
    localparam logic [BIN_W:0]   ONE_Q16 = (BIN_W+1)'(32'h0001_0000);
    localparam logic [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
    localparam logic [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd2;

    // Reset value of max_length
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 11'd1024;

    // Action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_ACCUM   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // One input transaction
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] value;
        logic [WGT_W-1:0] weight;
        logic [IDX_W-1:0] index;
    } item_t;

    // Configuration registers
    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
        logic             use_weights;
    } cfg_t;

    // Largest-value tracker
    typedef struct packed {
        logic [LEN_W-1:0] largest;
        logic             any;
    } track_t;

    // Bin write-back
    typedef struct packed {
        logic              en;
        logic [BIN_AW-1:0] addr;
        logic [BIN_W-1:0]  data;
    } bin_wr_t;

    // Result transaction
    typedef struct packed {
        logic [BIN_W-1:0] total;
        logic [LEN_W-1:0] length;
    } result_t;

endpackage

FILE: sv/wbc_if.sv
// ----------------------------------------------------------------------------
// wbc_if
// Valid/ready channels of the weighted bin counter.
// ----------------------------------------------------------------------------

// Sample channel: accumulate, read and restart requests
interface wbc_sample_if;
    import wbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] sample_value;
    logic signed [WGT_W-1:0] sample_weight;
    logic [IDX_W-1:0]        bin_index;

    modport source (
        output valid, action, sample_value, sample_weight, bin_index,
        input  ready
    );
    modport sink (
        input  valid, action, sample_value, sample_weight, bin_index,
        output ready
    );
endinterface

// Result channel: one transaction per read request
interface wbc_result_if;
    import wbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [BIN_W-1:0] bin_total;
    logic [LEN_W-1:0]        output_length;

    modport source (
        output valid, bin_total, output_length,
        input  ready
    );
    modport sink (
        input  valid, bin_total, output_length,
        output ready
    );
endinterface

FILE: sv/weighted_bin_counter.sv
// ----------------------------------------------------------------------------
// weighted_bin_counter
// Weighted histogram with saturating Q32.16 bins and read-and-clear access.
//
//   Channel   Dir  Payload                                          Handshake
//   samples   in   action, sample_value, sample_weight, bin_index   valid/ready
//   results   out  bin_total, output_length                         valid/ready
//   cfg       in   cfg_index, cfg_data                              cfg_wr_en
//
// One transaction per cycle while samples.ready is high; a read's result passes
// through stage 1 and the result register before results.valid rises. Read data
// comes from a one-port-write, one-port-read bin RAM with a bypass for
// back-to-back updates of the same bin. After reset a clearing pass writes zero
// to all NUM_BINS bins, with samples.ready low; configuration writes are taken meanwhile.
// A read waiting behind an unaccepted result stalls the sample channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_bin_counter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbc_pkg::CFG_DATA_W-1:0] cfg_data,
    wbc_sample_if.sink                     samples,
    wbc_result_if.source                   results
);
    import wbc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    localparam logic [BIN_AW-1:0] CLR_LAST = BIN_AW'(NUM_BINS - 1);

    state_t            state_reg;
    logic [BIN_AW-1:0] clr_cnt_reg;
    cfg_t              cfg_reg;
    track_t            track_reg;

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [BIN_W-1:0]  mem_q_reg;
    logic              byp_hit_reg;
    logic [BIN_W-1:0]  byp_data_reg;

    logic              out_valid_reg;
    result_t           out_data_reg;

    logic [BIN_W-1:0]  bin_mem [NUM_BINS];

    logic              accept;
    logic [BIN_AW-1:0] raddr;
    logic [BIN_W-1:0]  cur_bin;
    logic              s1_fire;
    logic              mem_we;
    logic [BIN_AW-1:0] mem_waddr;
    logic [BIN_W-1:0]  mem_wdata;
    logic              byp_hit_next;

    bin_wr_t           upd_wr;
    track_t            upd_track;
    logic              upd_has_result;
    result_t           upd_result;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length  <= '0;
            cfg_reg.max_length  <= MAX_LENGTH_RST;
            cfg_reg.use_weights <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN_LENGTH:  cfg_reg.min_length  <= cfg_data[LEN_W-1:0];
                REG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data[LEN_W-1:0];
                REG_USE_WEIGHTS: cfg_reg.use_weights <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + BIN_AW'(1);
                    if (clr_cnt_reg == CLR_LAST)
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    state_reg <= ST_RUN;
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Handshake and read address
    always_comb
    begin
        s1_fire = s1_valid_reg && !(upd_has_result && out_valid_reg && !results.ready);
        samples.ready = (state_reg == ST_RUN) && (!s1_valid_reg || s1_fire);
        accept = samples.valid && samples.ready;
        if (samples.action == ACT_READ)
            raddr = BIN_AW'(samples.bin_index);
        else
            raddr = BIN_AW'($unsigned(samples.sample_value));
    end

    // Write port: clearing pass or stage write-back
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_fire && upd_wr.en;
            mem_waddr = upd_wr.addr;
            mem_wdata = upd_wr.data;
        end
        byp_hit_next = s1_fire && upd_wr.en && (upd_wr.addr == raddr);
    end

    // Bin RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (accept)
            mem_q_reg <= bin_mem[raddr];
    end

    // Stage 1 capture, with bypass of a same-cycle write to the same bin
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.action <= samples.action;
            s1_item_reg.value  <= samples.sample_value;
            s1_item_reg.weight <= samples.sample_weight;
            s1_item_reg.index  <= samples.bin_index;
            byp_hit_reg        <= byp_hit_next;
            byp_data_reg       <= upd_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    assign cur_bin = byp_hit_reg ? byp_data_reg : mem_q_reg;

    wbc_bin_update u_update (
        .item       (s1_item_reg),
        .cur_bin    (cur_bin),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .wr         (upd_wr),
        .track_next (upd_track),
        .has_result (upd_has_result),
        .result     (upd_result)
    );

    // Largest-value tracker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_reg <= '0;
        else if (s1_fire)
            track_reg <= upd_track;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && upd_has_result)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && upd_has_result)
            out_data_reg <= upd_result;
    end

    assign results.valid         = out_valid_reg;
    assign results.bin_total     = $signed(out_data_reg.total);
    assign results.output_length = out_data_reg.length;

    // Checks
    `WBC_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_n |-> !samples.ready,
        "sample channel ready during reset")
    `WBC_ASSERT(a_accept_fills_stage, (samples.valid && samples.ready) |=> s1_valid_reg,
        "accepted transaction did not reach stage 1")
    `WBC_ASSERT(a_length_capped,
        results.valid |-> (results.output_length <= cfg_reg.max_length),
        "output length above max_length")
    `WBC_ASSERT(a_clear_ends,
        (state_reg == ST_CLEAR && clr_cnt_reg == CLR_LAST) |=> (state_reg == ST_RUN),
        "clearing pass did not finish")

endmodule

FILE: sv/wbc_bin_update.sv
// ----------------------------------------------------------------------------
// wbc_bin_update
// Per-transaction datapath: saturating bin add, read-and-clear, length calc.
// ----------------------------------------------------------------------------
module wbc_bin_update (
    input  wbc_pkg::item_t          item,
    input  logic [wbc_pkg::BIN_W-1:0] cur_bin,
    input  wbc_pkg::cfg_t           cfg,
    input  wbc_pkg::track_t         track,
    output wbc_pkg::bin_wr_t        wr,
    output wbc_pkg::track_t         track_next,
    output logic                    has_result,
    output wbc_pkg::result_t        result
);
    import wbc_pkg::*;

    logic [LEN_W-1:0]   cap;
    logic [LEN_W:0]     seen_len;
    logic [LEN_W:0]     raised_len;
    logic [LEN_W:0]     cap_len;
    logic [VAL_W-2:0]   mag;
    logic [LEN_W-1:0]   clipped;
    logic               kept;
    logic               idx_ok;
    logic [BIN_W:0]     addend;
    logic [BIN_W:0]     sum;
    logic [BIN_W-1:0]   sat_sum;

    // Length cap: smaller of max_length and the bin count
    always_comb
    begin
        if (32'(cfg.max_length) < 32'(NUM_BINS))
            cap = cfg.max_length;
        else
            cap = LEN_W'(NUM_BINS);
    end

    // Output length from tracker, raised to min_length, then capped
    always_comb
    begin
        seen_len   = track.any ? ({1'b0, track.largest} + (LEN_W+1)'(1)) : '0;
        raised_len = (seen_len < {1'b0, cfg.min_length}) ? {1'b0, cfg.min_length}
                                                         : seen_len;
        cap_len    = (raised_len > {1'b0, cap}) ? {1'b0, cap} : raised_len;
    end

    // Value magnitude checks
    always_comb
    begin
        mag     = item.value[VAL_W-2:0];
        clipped = (mag > (VAL_W-1)'(TRACK_MAX)) ? TRACK_MAX : LEN_W'(mag);
        kept    = !item.value[VAL_W-1] && (mag < (VAL_W-1)'(cap));
        idx_ok  = 32'(item.index) < 32'(NUM_BINS);
    end

    // Saturating add in Q32.16
    always_comb
    begin
        addend  = cfg.use_weights ? {{(BIN_W+1-WGT_W){item.weight[WGT_W-1]}}, item.weight}
                                  : ONE_Q16;
        sum     = {cur_bin[BIN_W-1], cur_bin} + addend;
        if (sum[BIN_W] != sum[BIN_W-1])
            sat_sum = sum[BIN_W] ? BIN_MIN : BIN_MAX;
        else
            sat_sum = sum[BIN_W-1:0];
    end

    // Action decode
    always_comb
    begin
        wr            = '0;
        track_next    = track;
        has_result    = 1'b0;
        result.total  = '0;
        result.length = cap_len[LEN_W-1:0];
        unique case (item.action)
            ACT_ACCUM:
            begin
                if (!item.value[VAL_W-1])
                begin
                    if (!track.any || clipped > track.largest)
                        track_next.largest = clipped;
                    track_next.any = 1'b1;
                end
                wr.en   = kept;
                wr.addr = BIN_AW'(mag);
                wr.data = sat_sum;
            end
            ACT_READ:
            begin
                has_result   = 1'b1;
                result.total = idx_ok ? cur_bin : '0;
                wr.en        = idx_ok;
                wr.addr      = BIN_AW'(item.index);
                wr.data      = '0;
            end
            ACT_RESTART:
            begin
                track_next = '0;
            end
            default:
            begin
                wr = '0;
            end
        endcase
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted bin counter.
//
// Samples are driven over the valid/ready sample channel while a
// scoreboard-side histogram keeps its own bins, tracker and register copy.
// Every read-and-clear transaction queues its predicted bin total and
// output length. The result sink checks each returned transaction against
// the oldest prediction.
// Tests: reset defaults and dropped values, register corners, long result
// backpressure, then randomized phases.
// ----------------------------------------------------------------------------
module tb;
    import wbc_pkg::*;

    localparam logic [ACT_W-1:0]       ACT_IGNORED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0]   REG_UNUSED   = 2'd3;
    localparam logic signed [WGT_W-1:0] WGT_TOP     = 32'sh7FFF_FFFF;
    localparam logic signed [WGT_W-1:0] WGT_BOTTOM  = 32'sh8000_0000;
    localparam longint SUM_HI       = longint'($signed(BIN_MAX));
    localparam longint SUM_LO       = longint'($signed(BIN_MIN));
    localparam int     DRAIN_CYCLES = 8;
    localparam int     CYCLE_LIMIT  = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wbc_sample_if samp_ch ();
    wbc_result_if res_ch ();

    weighted_bin_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samp_ch),
        .results   (res_ch)
    );

    // Scoreboard histogram state and register copy
    logic signed [BIN_W-1:0] model_bins [NUM_BINS];
    logic [LEN_W-1:0]        model_largest;
    bit                      model_any;
    logic [LEN_W-1:0]        cur_min_len;
    logic [LEN_W-1:0]        cur_max_len;
    bit                      cur_use_w;
    result_t                 pending_reads [$];

    // Run control and bookkeeping
    bit src_idle_on;
    bit sink_idle_on;
    int long_hold_left;
    int err_count;
    int items_sent;
    int reads_checked;
    int settings_used;
    int cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    // Length cap: max_length, but never more than the bin count
    function automatic int bin_cap();
        return (int'(cur_max_len) < NUM_BINS) ? int'(cur_max_len) : NUM_BINS;
    endfunction

    function automatic logic [LEN_W-1:0] reported_length();
        int len;
        int cap;
        cap = bin_cap();
        len = model_any ? int'(model_largest) + 1 : 0;
        if (len < int'(cur_min_len))
            len = int'(cur_min_len);
        if (len > cap)
            len = cap;
        return LEN_W'(len);
    endfunction

    // Apply one accepted transaction to the scoreboard histogram
    function automatic void histogram_update(input logic [ACT_W-1:0] act,
                                             input logic signed [VAL_W-1:0] val,
                                             input logic signed [WGT_W-1:0] wgt,
                                             input logic [IDX_W-1:0] idx);
        int      v;
        int      tracked;
        longint  sum;
        result_t want;
        v = int'(val);
        case (act)
            ACT_ACCUM:
            begin
                // negative values are ignored entirely
                if (v >= 0)
                begin
                    // dropped values still move the tracker
                    tracked = (v > int'(TRACK_MAX)) ? int'(TRACK_MAX) : v;
                    if (!model_any || tracked > int'(model_largest))
                        model_largest = LEN_W'(tracked);
                    model_any = 1'b1;
                    if (v < bin_cap())
                    begin
                        sum = longint'(model_bins[v])
                            + (cur_use_w ? longint'(wgt) : longint'(ONE_Q16));
                        if (sum > SUM_HI)
                            sum = SUM_HI;
                        else if (sum < SUM_LO)
                            sum = SUM_LO;
                        model_bins[v] = BIN_W'(sum);
                    end
                end
            end
            ACT_READ:
            begin
                want.total     = model_bins[idx];
                model_bins[idx] = '0;
                want.length    = reported_length();
                pending_reads.insert(pending_reads.size(), want);
            end
            ACT_RESTART:
            begin
                model_any     = 1'b0;
                model_largest = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string what, longint exp_v, longint got_v);
        err_count++;
        if (err_count <= 10)
            $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
    endfunction

    // Long receiver hold-off, counted down here
    initial
    begin : hold_timer
        forever
        begin
            @(posedge clk);
            if (long_hold_left > 0)
                long_hold_left--;
        end
    end

    // Result sink: random stalls, check each transaction against the oldest read
    initial
    begin : result_sink
        int      hold;
        result_t want;
        hold = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_reads.size() == 0)
                    note_mismatch("result with no read pending", longint'(0),
                                  longint'(res_ch.bin_total));
                else
                begin
                    want = pending_reads.pop_front();
                    if (res_ch.bin_total !== want.total)
                        note_mismatch("bin_total", longint'($signed(want.total)),
                                      longint'(res_ch.bin_total));
                    if (res_ch.output_length !== want.length)
                        note_mismatch("output_length", longint'(want.length),
                                      longint'(res_ch.output_length));
                    reads_checked++;
                end
                hold = sink_idle_on ? $urandom_range(0, 3) : 0;
            end
            else if (hold > 0)
                hold--;
            res_ch.ready <= (hold == 0) && (long_hold_left == 0);
        end
    end

    // Send one sample transaction; predict once it is accepted
    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic signed [VAL_W-1:0] val,
                             input logic signed [WGT_W-1:0] wgt,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            samp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp_ch.valid         <= 1'b1;
        samp_ch.action        <= act;
        samp_ch.sample_value  <= val;
        samp_ch.sample_weight <= wgt;
        samp_ch.bin_index     <= idx;
        do
            @(posedge clk);
        while (samp_ch.ready !== 1'b1);
        histogram_update(act, val, wgt, idx);
        items_sent++;
    endtask

    // Stop sending, wait for every pending read, then let the pipeline settle
    task automatic wait_idle();
        samp_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes; a junk write to the unused index comes first
    task automatic set_config(input logic [LEN_W-1:0] mn, input logic [LEN_W-1:0] mx,
                              input bit uw);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= REG_MIN_LENGTH;
        cfg_data  <= mn;
        @(posedge clk);
        cur_min_len = mn;
        cfg_index <= REG_MAX_LENGTH;
        cfg_data  <= mx;
        @(posedge clk);
        cur_max_len = mx;
        cfg_index <= REG_USE_WEIGHTS;
        cfg_data  <= CFG_DATA_W'(uw);
        @(posedge clk);
        cur_use_w = uw;
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Reset register values, dropped values, restart, unused action
    task automatic test_reset_defaults();
        send_item(ACT_READ, 0, 0, 0);             // nothing seen: length zero
        send_item(ACT_ACCUM, 0, 0, 0);
        send_item(ACT_ACCUM, 0, WGT_TOP, 0);      // weights off: weight ignored
        send_item(ACT_ACCUM, 1023, 0, 0);
        send_item(ACT_ACCUM, -1, 0, 0);
        send_item(ACT_ACCUM, 16'sh8000, 0, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_RESTART, 0, 0, 0);
        send_item(ACT_ACCUM, 16'sh7FFF, 0, 0);    // dropped, tracked as max
        send_item(ACT_ACCUM, 1024, 0, 0);
        send_item(ACT_IGNORED, 5, WGT_TOP, 5);
        send_item(ACT_READ, 0, 0, 1023);
        send_item(ACT_RESTART, 0, 0, 0);
        send_item(ACT_ACCUM, 7, 0, 0);
        send_item(ACT_READ, 0, 0, 7);
        send_item(ACT_READ, 0, 0, 0);             // already cleared
    endtask

    // Register corners: min above cap, max zero, max above bin count
    task automatic test_config_corners();
        wait_idle();
        set_config(20, 1024, 1'b1);
        send_item(ACT_ACCUM, 3, WGT_TOP, 0);
        send_item(ACT_ACCUM, 3, WGT_BOTTOM, 0);
        send_item(ACT_READ, 0, 0, 3);
        wait_idle();
        set_config(2047, 16, 1'b0);
        send_item(ACT_ACCUM, 15, 0, 0);
        send_item(ACT_ACCUM, 16, 0, 0);
        send_item(ACT_READ, 0, 0, 15);
        wait_idle();
        set_config(5, 0, 1'b1);
        send_item(ACT_ACCUM, 0, WGT_TOP, 0);
        send_item(ACT_READ, 0, 0, 0);
        wait_idle();
        set_config(0, 2047, 1'b1);
        send_item(ACT_ACCUM, 1023, -5, 0);
        send_item(ACT_READ, 0, 0, 1023);
        wait_idle();
        set_config(0, 1, 1'b0);
        send_item(ACT_ACCUM, 0, 0, 0);
        send_item(ACT_ACCUM, 1, 0, 0);
        send_item(ACT_READ, 0, 0, 0);
    endtask

    // Receiver holds off long enough to stall the sample channel
    task automatic test_backpressure();
        wait_idle();
        set_config(0, 1024, 1'b1);
        src_idle_on    = 1'b0;
        sink_idle_on   = 1'b0;
        long_hold_left = 150;
        for (int k = 0; k < 40; k++)
            send_item((k % 2 != 0) ? ACT_READ : ACT_ACCUM, VAL_W'(k % 8),
                      WGT_W'($urandom), IDX_W'(k % 8));
        wait_idle();
    endtask

    // Random phases, each under its own register setting
    task automatic test_random();
        int                      hot_hi;
        int                      pick;
        logic [LEN_W-1:0]        mn;
        logic [LEN_W-1:0]        mx;
        logic [ACT_W-1:0]        act;
        logic signed [VAL_W-1:0] val;
        logic signed [WGT_W-1:0] wgt;
        logic [IDX_W-1:0]        idx;
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin mn = LEN_W'(1024); mx = LEN_W'(1024); end
                1: begin mn = LEN_W'(0);    mx = LEN_W'(1);    end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: mn = LEN_W'(0);
                        1: mn = LEN_W'($urandom_range(0, 64));
                        2: mn = LEN_W'(2047);
                        default: mn = LEN_W'($urandom_range(0, 2047));
                    endcase
                    case ($urandom_range(0, 3))
                        0: mx = LEN_W'($urandom_range(1, 64));
                        1: mx = LEN_W'(2047);
                        2: mx = LEN_W'(1024);
                        default: mx = LEN_W'($urandom_range(1, 2047));
                    endcase
                end
            endcase
            set_config(mn, mx, 1'($urandom_range(0, 1)));
            hot_hi = ((bin_cap() < 48) ? bin_cap() : 48) - 1;
            for (int n = 0; n < 200; n++)
            begin
                // switch idling on and off in stretches
                if (n % 40 == 0)
                begin
                    src_idle_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
                    sink_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                val  = VAL_W'($urandom);
                idx  = IDX_W'($urandom);
                wgt  = WGT_W'($urandom);
                if ($urandom_range(0, 7) == 0)
                    wgt = ($urandom_range(0, 1) != 0) ? WGT_TOP : WGT_BOTTOM;
                if (pick < 58)
                begin
                    act = ACT_ACCUM;
                    val = VAL_W'($urandom_range(0, hot_hi));
                end
                else if (pick < 66)
                    act = ACT_ACCUM;              // full-range noise
                else if (pick < 70)
                begin
                    act = ACT_ACCUM;
                    val = VAL_W'($urandom_range(0, 2100));
                end
                else if (pick < 94)
                begin
                    act = ACT_READ;
                    if ($urandom_range(0, 4) != 0)
                        idx = IDX_W'($urandom_range(0, hot_hi));
                end
                else if (pick < 97)
                    act = ACT_RESTART;
                else
                    act = ACT_IGNORED;
                send_item(act, val, wgt, idx);
            end
        end
    endtask

    // Test sequence
    initial
    begin : main
        foreach (model_bins[i])
            model_bins[i] = '0;
        model_largest  = '0;
        model_any      = 1'b0;
        cur_min_len    = '0;
        cur_max_len    = MAX_LENGTH_RST;
        cur_use_w      = 1'b0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        long_hold_left = 0;
        err_count      = 0;
        items_sent     = 0;
        reads_checked  = 0;
        settings_used  = 0;

        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        samp_ch.valid         = 1'b0;
        samp_ch.action        = '0;
        samp_ch.sample_value  = '0;
        samp_ch.sample_weight = '0;
        samp_ch.bin_index     = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_config_corners();
        test_backpressure();
        test_random();
        wait_idle();

        $display("Run: %0d sample transactions, %0d reads checked, %0d register settings",
                 items_sent, reads_checked, settings_used);
        $display("Covered dropped and tracked values, restart, register corners, stalls");
        if (err_count == 0 && pending_reads.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
